### sv/shg_pkg.sv
package shg_pkg;

    localparam int CMD_W   = 2;
    localparam int COORD_W = 24;
    localparam int INV_W   = 32;
    localparam int SPACE_W = 52;
    localparam int AXIS_W  = 10;
    localparam int KEY_W   = 31;
    localparam int INDEX_W = 9;
    localparam int ACC_W   = 50;

    localparam logic [31:0] KEY_HASH = 32'd2654435761;
    localparam logic [AXIS_W-1:0] AXIS_BIAS = 10'd511;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    localparam logic CFG_INV_CELL = 1'b0;
    localparam logic CFG_SPACING  = 1'b1;

    localparam logic [INV_W-1:0]   INV_RESET   = 32'd65536;
    localparam logic [SPACE_W-1:0] SPACE_RESET = 52'd4294967296;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_CLR,
        DP_CELL,
        DP_KEY,
        DP_HASH,
        DP_PROBE,
        DP_HEAD,
        DP_DIST,
        DP_LINK,
        DP_NBR,
        DP_INS
    } t_dp_op;

    typedef enum logic [2:0] {
        FIN_NONE,
        FIN_OK,
        FIN_FULL,
        FIN_CLOSE,
        FIN_INS
    } t_fin;

    typedef struct packed {
        t_dp_op op;
        t_fin   fin;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic clr_last;
        logic axis_last;
        logic probe_hit;
        logic probe_empty;
        logic probe_last;
        logic walk_end;
        logic close;
        logic nbr_last;
    } t_dp_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_CELL,
        S_KEY,
        S_HASH,
        S_PWAIT,
        S_PCHK,
        S_INS,
        S_WALK,
        S_SWAIT,
        S_DIST,
        S_CMP,
        S_NEXT
    } t_state;

endpackage

### sv/spatial_hash_spacing_grid.sv
// Channel   Handshake                    Payload
// command   start / busy                 i_command, i_point_x, i_point_y, i_point_z
// result    o_done (one-cycle strobe)    o_status, o_too_close, o_site_index
// config    i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// Clear sweeps the slot table, one slot a cycle.
// Insert probes the slot table from the hashed slot of its cell. Query visits each neighbor
// cell, probes for its slot and, when the cell has a chain, walks the sites on that chain;
// a close site ends the item at its compare.
// After reset the same sweep runs before start is taken.
// The result is registered, so the next item may start in the strobe cycle.
// The receiver cannot stall; each result stays on the ports until the next is written.
module spatial_hash_spacing_grid #(
    parameter int SITE_CAPACITY = 512,
    parameter int SLOT_COUNT    = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [shg_pkg::CMD_W-1:0]          i_command,
    input  logic signed [shg_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [shg_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [shg_pkg::COORD_W-1:0] i_point_z,
    output logic                               o_done,
    output logic                               o_status,
    output logic                               o_too_close,
    output logic [shg_pkg::INDEX_W-1:0]        o_site_index,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_index,
    input  logic [shg_pkg::SPACE_W-1:0]        i_cfg_data
);
    import shg_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    shg_ctrl u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_command(i_command),
        .i_stat(dp_stat),
        .o_cmd(dp_cmd),
        .o_busy(busy),
        .o_done(o_done)
    );

    shg_dp #(
        .SITE_CAPACITY(SITE_CAPACITY),
        .SLOT_COUNT(SLOT_COUNT)
    ) u_dp (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd(dp_cmd),
        .o_stat(dp_stat),
        .i_command(i_command),
        .i_point_x(i_point_x),
        .i_point_y(i_point_y),
        .i_point_z(i_point_z),
        .i_cfg_we(i_cfg_valid & o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_status(o_status),
        .o_too_close(o_too_close),
        .o_site_index(o_site_index)
    );

endmodule

### sv/shg_ram.sv
module shg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/shg_dp.sv
module shg_dp #(
    parameter int SITE_CAPACITY = 512,
    parameter int SLOT_COUNT    = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  shg_pkg::t_dp_cmd               i_cmd,
    output shg_pkg::t_dp_stat              o_stat,
    input  logic [shg_pkg::CMD_W-1:0]      i_command,
    input  logic signed [shg_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [shg_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [shg_pkg::COORD_W-1:0] i_point_z,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [shg_pkg::SPACE_W-1:0]    i_cfg_data,
    output logic                           o_status,
    output logic                           o_too_close,
    output logic [shg_pkg::INDEX_W-1:0]    o_site_index
);
    import shg_pkg::*;

    localparam int SB = $clog2(SLOT_COUNT);
    localparam int AB = $clog2(SITE_CAPACITY);
    localparam int LB = $clog2(SITE_CAPACITY + 1);
    localparam logic [31:0]   SLOT_MASK = 32'(SLOT_COUNT - 1);
    localparam logic [SB-1:0] SLOT_LAST = SB'(SLOT_COUNT - 1);
    localparam logic [LB-1:0] CAP       = LB'(SITE_CAPACITY);

    logic [INV_W-1:0]   r_inv;
    logic [SPACE_W-1:0] r_spacing;
    logic signed [COORD_W-1:0] r_px, r_py, r_pz;
    logic [AXIS_W-1:0]  r_cx, r_cy, r_cz;
    logic [1:0]         r_axis;
    logic [1:0]         r_ni, r_nj, r_nk;
    logic [KEY_W-1:0]   r_key;
    logic [SB-1:0]      r_slot;
    logic [SB-1:0]      r_probe_n;
    logic [SB-1:0]      r_clr_addr;
    logic [LB-1:0]      r_link;
    logic [LB-1:0]      r_steps;
    logic [LB-1:0]      r_count;
    logic [ACC_W-1:0]   r_acc;
    logic               r_status;
    logic               r_too_close;
    logic [INDEX_W-1:0] r_site_index;

    logic signed [COORD_W-1:0] p_sel, s_sel;
    logic signed [56:0]        cell_prod;
    logic [63:0]               hash_prod;
    logic signed [COORD_W:0]   diff;
    logic signed [2*COORD_W+1:0] sq;
    logic [AXIS_W-1:0]         ux, uy, uz;
    logic [KEY_W-1:0]          key_n;
    logic [KEY_W-1:0]          slot_rdata;
    logic [LB-1:0]             head_rdata;
    logic [LB-1:0]             link_rdata;
    logic [COORD_W-1:0]        sx_rdata, sy_rdata, sz_rdata;
    logic                      slot_we;
    logic [SB-1:0]             slot_waddr;
    logic [KEY_W-1:0]          slot_wdata;
    logic                      ins_we;
    logic [AB-1:0]             site_raddr;
    logic [AB-1:0]             site_waddr;
    logic [LB-1:0]             link_wdata;
    logic                      slot_empty;

    always_comb begin
        unique case (r_axis)
            2'd0:    p_sel = r_px;
            2'd1:    p_sel = r_py;
            default: p_sel = r_pz;
        endcase
        unique case (r_axis)
            2'd0:    s_sel = sx_rdata;
            2'd1:    s_sel = sy_rdata;
            default: s_sel = sz_rdata;
        endcase
    end

    assign cell_prod = p_sel * $signed({1'b0, r_inv});
    assign hash_prod = {33'd0, r_key} * {32'd0, KEY_HASH};
    assign diff      = {p_sel[COORD_W-1], p_sel} - {s_sel[COORD_W-1], s_sel};
    assign sq        = diff * diff;

    assign ux    = r_cx + AXIS_W'(r_ni) + AXIS_BIAS;
    assign uy    = r_cy + AXIS_W'(r_nj) + AXIS_BIAS;
    assign uz    = r_cz + AXIS_W'(r_nk) + AXIS_BIAS;
    assign key_n = KEY_W'({ux, uy, uz}) + KEY_W'(1);

    assign slot_empty = (slot_rdata == '0);
    assign ins_we     = (i_cmd.op == DP_INS);
    assign slot_we    = (i_cmd.op == DP_CLR) || ins_we;
    assign slot_waddr = (i_cmd.op == DP_CLR) ? r_clr_addr : r_slot;
    assign slot_wdata = (i_cmd.op == DP_CLR) ? '0 : r_key;
    assign site_raddr = AB'(r_link - LB'(1));
    assign site_waddr = AB'(r_count);
    assign link_wdata = slot_empty ? '0 : head_rdata;

    shg_ram #(.WIDTH(KEY_W), .DEPTH(SLOT_COUNT)) u_slot_keys (
        .i_clk(i_clk), .i_we(slot_we), .i_waddr(slot_waddr), .i_wdata(slot_wdata),
        .i_raddr(r_slot), .o_rdata(slot_rdata)
    );
    shg_ram #(.WIDTH(LB), .DEPTH(SLOT_COUNT)) u_heads (
        .i_clk(i_clk), .i_we(ins_we), .i_waddr(r_slot), .i_wdata(r_count + LB'(1)),
        .i_raddr(r_slot), .o_rdata(head_rdata)
    );
    shg_ram #(.WIDTH(LB), .DEPTH(SITE_CAPACITY)) u_links (
        .i_clk(i_clk), .i_we(ins_we), .i_waddr(site_waddr), .i_wdata(link_wdata),
        .i_raddr(site_raddr), .o_rdata(link_rdata)
    );
    shg_ram #(.WIDTH(COORD_W), .DEPTH(SITE_CAPACITY)) u_site_x (
        .i_clk(i_clk), .i_we(ins_we), .i_waddr(site_waddr), .i_wdata(r_px),
        .i_raddr(site_raddr), .o_rdata(sx_rdata)
    );
    shg_ram #(.WIDTH(COORD_W), .DEPTH(SITE_CAPACITY)) u_site_y (
        .i_clk(i_clk), .i_we(ins_we), .i_waddr(site_waddr), .i_wdata(r_py),
        .i_raddr(site_raddr), .o_rdata(sy_rdata)
    );
    shg_ram #(.WIDTH(COORD_W), .DEPTH(SITE_CAPACITY)) u_site_z (
        .i_clk(i_clk), .i_we(ins_we), .i_waddr(site_waddr), .i_wdata(r_pz),
        .i_raddr(site_raddr), .o_rdata(sz_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv      <= INV_RESET;
            r_spacing  <= SPACE_RESET;
            r_count    <= '0;
            r_clr_addr <= '0;
            r_axis     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_INV_CELL: r_inv     <= i_cfg_data[INV_W-1:0];
                    default:      r_spacing <= i_cfg_data;
                endcase
            end
            unique case (i_cmd.op)
                DP_LOAD: begin
                    r_clr_addr <= '0;
                    r_axis     <= '0;
                end
                DP_CLR: begin
                    r_count    <= '0;
                    r_clr_addr <= r_clr_addr + SB'(1);
                end
                DP_CELL, DP_DIST: begin
                    r_axis <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                end
                DP_INS: begin
                    r_count <= r_count + LB'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_LOAD: begin
                r_px <= i_point_x;
                r_py <= i_point_y;
                r_pz <= i_point_z;
                if (i_command == CMD_INSERT) begin
                    r_ni <= 2'd1;
                    r_nj <= 2'd1;
                    r_nk <= 2'd1;
                end else begin
                    r_ni <= 2'd0;
                    r_nj <= 2'd0;
                    r_nk <= 2'd0;
                end
            end
            DP_CELL: begin
                unique case (r_axis)
                    2'd0:    r_cx <= cell_prod[41:32];
                    2'd1:    r_cy <= cell_prod[41:32];
                    default: r_cz <= cell_prod[41:32];
                endcase
            end
            DP_KEY: r_key <= key_n;
            DP_HASH: begin
                r_slot    <= SB'(hash_prod[31:0] & SLOT_MASK);
                r_probe_n <= '0;
            end
            DP_PROBE: begin
                r_slot    <= (r_slot == SLOT_LAST) ? '0 : r_slot + SB'(1);
                r_probe_n <= r_probe_n + SB'(1);
            end
            DP_HEAD: begin
                r_link  <= head_rdata;
                r_steps <= '0;
            end
            DP_DIST: begin
                if (r_axis == 2'd0) begin
                    r_acc <= ACC_W'(sq);
                end else begin
                    r_acc <= r_acc + ACC_W'(sq);
                end
            end
            DP_LINK: begin
                r_link  <= link_rdata;
                r_steps <= r_steps + LB'(1);
            end
            DP_NBR: begin
                if (r_nk == 2'd2) begin
                    r_nk <= 2'd0;
                    if (r_nj == 2'd2) begin
                        r_nj <= 2'd0;
                        r_ni <= r_ni + 2'd1;
                    end else begin
                        r_nj <= r_nj + 2'd1;
                    end
                end else begin
                    r_nk <= r_nk + 2'd1;
                end
            end
            default: begin
            end
        endcase

        unique case (i_cmd.fin)
            FIN_OK: begin
                r_status     <= 1'b0;
                r_too_close  <= 1'b0;
                r_site_index <= '0;
            end
            FIN_FULL: begin
                r_status     <= 1'b1;
                r_too_close  <= 1'b0;
                r_site_index <= '0;
            end
            FIN_CLOSE: begin
                r_status     <= 1'b0;
                r_too_close  <= 1'b1;
                r_site_index <= '0;
            end
            FIN_INS: begin
                r_status     <= 1'b0;
                r_too_close  <= 1'b0;
                r_site_index <= INDEX_W'(r_count);
            end
            default: begin
            end
        endcase
    end

    assign o_stat.full        = (r_count >= CAP);
    assign o_stat.clr_last    = (r_clr_addr == SLOT_LAST);
    assign o_stat.axis_last   = (r_axis == 2'd2);
    assign o_stat.probe_hit   = slot_empty || (slot_rdata == r_key);
    assign o_stat.probe_empty = slot_empty;
    assign o_stat.probe_last  = (r_probe_n == SLOT_LAST);
    assign o_stat.walk_end    = (r_link == '0) || (r_steps == CAP) || (r_link > CAP);
    assign o_stat.close       = ({2'b00, r_acc} < r_spacing);
    assign o_stat.nbr_last    = (r_ni == 2'd2) && (r_nj == 2'd2) && (r_nk == 2'd2);

    assign o_status     = r_status;
    assign o_too_close  = r_too_close;
    assign o_site_index = r_site_index;

endmodule

### sv/shg_ctrl.sv
module shg_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [shg_pkg::CMD_W-1:0] i_command,
    input  shg_pkg::t_dp_stat         i_stat,
    output shg_pkg::t_dp_cmd          o_cmd,
    output logic                      o_busy,
    output logic                      o_done
);
    import shg_pkg::*;

    t_state r_state, n_state;
    logic [CMD_W-1:0] r_cmd, n_cmd;
    logic r_reply, n_reply;
    logic r_done, n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cmd   <= CMD_CLEAR;
            r_reply <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
            r_reply <= n_reply;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_reply   = r_reply;
        n_done    = 1'b0;
        o_cmd.op  = DP_NOP;
        o_cmd.fin = FIN_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = DP_LOAD;
                    n_cmd    = i_command;
                    priority if (i_command == CMD_CLEAR) begin
                        n_reply = 1'b1;
                        n_state = S_CLR;
                    end else if (i_command == CMD_INSERT) begin
                        if (i_stat.full) begin
                            o_cmd.fin = FIN_FULL;
                            n_done    = 1'b1;
                        end else begin
                            n_state = S_CELL;
                        end
                    end else if (i_command == CMD_QUERY) begin
                        n_state = S_CELL;
                    end else begin
                        o_cmd.fin = FIN_OK;
                        n_done    = 1'b1;
                    end
                end
            end
            S_CLR: begin
                o_cmd.op = DP_CLR;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                    if (r_reply) begin
                        o_cmd.fin = FIN_OK;
                        n_done    = 1'b1;
                    end
                end
            end
            S_CELL: begin
                o_cmd.op = DP_CELL;
                if (i_stat.axis_last) begin
                    n_state = S_KEY;
                end
            end
            S_KEY: begin
                o_cmd.op = DP_KEY;
                n_state  = S_HASH;
            end
            S_HASH: begin
                o_cmd.op = DP_HASH;
                n_state  = S_PWAIT;
            end
            S_PWAIT: n_state = S_PCHK;
            S_PCHK: begin
                priority if (i_stat.probe_hit) begin
                    if (r_cmd == CMD_INSERT) begin
                        n_state = S_INS;
                    end else if (i_stat.probe_empty) begin
                        n_state = S_NEXT;
                    end else begin
                        o_cmd.op = DP_HEAD;
                        n_state  = S_WALK;
                    end
                end else if (i_stat.probe_last) begin
                    if (r_cmd == CMD_INSERT) begin
                        o_cmd.fin = FIN_FULL;
                        n_done    = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        n_state = S_NEXT;
                    end
                end else begin
                    o_cmd.op = DP_PROBE;
                    n_state  = S_PWAIT;
                end
            end
            S_INS: begin
                o_cmd.op  = DP_INS;
                o_cmd.fin = FIN_INS;
                n_done    = 1'b1;
                n_state   = S_IDLE;
            end
            S_WALK: begin
                n_state = i_stat.walk_end ? S_NEXT : S_SWAIT;
            end
            S_SWAIT: n_state = S_DIST;
            S_DIST: begin
                o_cmd.op = DP_DIST;
                if (i_stat.axis_last) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.close) begin
                    o_cmd.fin = FIN_CLOSE;
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    o_cmd.op = DP_LINK;
                    n_state  = S_WALK;
                end
            end
            S_NEXT: begin
                if (i_stat.nbr_last) begin
                    o_cmd.fin = FIN_OK;
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    o_cmd.op = DP_NBR;
                    n_state  = S_KEY;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

### tb/sv/tb_spatial_hash_spacing_grid.sv
module tb_spatial_hash_spacing_grid;
    import shg_pkg::*;

    localparam int SITES       = 512;
    localparam int SLOTS       = 1024;
    localparam int WATCH_LIMIT = 200000;
    localparam int TAIL_ITEMS  = 150;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [CMD_W-1:0]          i_command;
    logic signed [COORD_W-1:0] i_point_x, i_point_y, i_point_z;
    logic                      o_done, o_status, o_too_close;
    logic [INDEX_W-1:0]        o_site_index;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic                      i_cfg_index;
    logic [SPACE_W-1:0]        i_cfg_data;

    always #5 i_clk = ~i_clk;

    spatial_hash_spacing_grid #(.SITE_CAPACITY(SITES), .SLOT_COUNT(SLOTS)) dut (.*);

    typedef struct {
        logic               status;
        logic               close;
        logic [INDEX_W-1:0] index;
    } grid_result_t;

    typedef struct {
        logic [CMD_W-1:0]          cmd;
        logic signed [COORD_W-1:0] x, y, z;
        bit                        typed;
        grid_result_t              res;
    } stim_row_t;

    grid_result_t pending_results[$];
    int fail_count, items_sent, close_hits, full_hits, clears_sent;
    bit gaps_on;

    // predictor copy of the block
    logic [INV_W-1:0]          inv_cell;
    logic [SPACE_W-1:0]        min_space_sq;
    logic [31:0]               grid_keys[SLOTS];
    logic [9:0]                grid_heads[SLOTS];
    logic [9:0]                site_next[SITES];
    logic signed [COORD_W-1:0] site_px[SITES], site_py[SITES], site_pz[SITES];
    int                        site_total;

    function automatic logic [9:0] cell_bits(logic signed [COORD_W-1:0] c);
        logic signed [63:0] p;
        p = 64'(c) * $signed({32'd0, inv_cell});
        return p[41:32];
    endfunction

    function automatic logic [31:0] cell_key(logic [9:0] cx, logic [9:0] cy, logic [9:0] cz);
        logic [9:0] ux, uy, uz;
        ux = cx + 10'd512;
        uy = cy + 10'd512;
        uz = cz + 10'd512;
        return {2'b00, ux, uy, uz} + 32'd1;
    endfunction

    function automatic bit locate_slot(logic [31:0] key, output int slot);
        logic [31:0] h;
        h = key * KEY_HASH;
        slot = int'(h & (SLOTS - 1));
        for (int n = 0; n < SLOTS; n++) begin
            if (grid_keys[slot] == 0 || grid_keys[slot] == key) return 1'b1;
            slot = (slot + 1) % SLOTS;
        end
        return 1'b0;
    endfunction

    function automatic logic [63:0] axis_sq(logic signed [COORD_W-1:0] a,
                                            logic signed [COORD_W-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return d * d;
    endfunction

    function automatic bit near_site(logic signed [COORD_W-1:0] x,
                                     logic signed [COORD_W-1:0] y,
                                     logic signed [COORD_W-1:0] z);
        logic [9:0]  cx, cy, cz;
        logic [9:0]  link;
        logic [63:0] d;
        int slot, steps, s;
        cx = cell_bits(x);
        cy = cell_bits(y);
        cz = cell_bits(z);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                for (int k = 0; k < 3; k++) begin
                    if (!locate_slot(cell_key(cx + 10'(i) - 10'd1, cy + 10'(j) - 10'd1,
                                              cz + 10'(k) - 10'd1), slot)) continue;
                    if (grid_keys[slot] == 0) continue;
                    link = grid_heads[slot];
                    for (steps = 0; link != 0 && steps < SITES; steps++) begin
                        s = int'(link) - 1;
                        d = axis_sq(x, site_px[s]) + axis_sq(y, site_py[s])
                            + axis_sq(z, site_pz[s]);
                        if (d < {12'd0, min_space_sq}) return 1'b1;
                        link = site_next[s];
                    end
                end
        return 1'b0;
    endfunction

    function automatic grid_result_t apply_command(logic [CMD_W-1:0] cmd,
                                                   logic signed [COORD_W-1:0] x,
                                                   logic signed [COORD_W-1:0] y,
                                                   logic signed [COORD_W-1:0] z);
        grid_result_t r;
        logic [31:0] key;
        int slot;
        r = '{1'b0, 1'b0, '0};
        case (cmd)
            CMD_CLEAR: begin
                foreach (grid_keys[i]) grid_keys[i] = 0;
                site_total = 0;
            end
            CMD_INSERT: begin
                key = cell_key(cell_bits(x), cell_bits(y), cell_bits(z));
                if (site_total >= SITES || !locate_slot(key, slot)) begin
                    r.status = 1'b1;
                end else begin
                    if (grid_keys[slot] == 0) begin
                        grid_keys[slot] = key;
                        grid_heads[slot] = 0;
                    end
                    site_px[site_total] = x;
                    site_py[site_total] = y;
                    site_pz[site_total] = z;
                    site_next[site_total] = grid_heads[slot];
                    grid_heads[slot] = 10'(site_total + 1);
                    r.index = INDEX_W'(site_total);
                    site_total++;
                end
            end
            CMD_QUERY: r.close = near_site(x, y, z);
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                grid_result_t w;
                w = pending_results.pop_front();
                if (o_status !== w.status) report_mismatch("status", o_status, w.status);
                if (o_too_close !== w.close) report_mismatch("too_close", o_too_close, w.close);
                if (o_site_index !== w.index) report_mismatch("site_index", o_site_index, w.index);
            end
        end
    end

    int idle_cycles;
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCH_LIMIT) begin
            $display("Watchdog expired with %0d results pending", pending_results.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_register(logic idx, logic [SPACE_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_INV_CELL) inv_cell = value[INV_W-1:0];
        else min_space_sq = value;
    endtask

    task automatic issue_item(stim_row_t row);
        grid_result_t r;
        i_command <= row.cmd;
        i_point_x <= row.x;
        i_point_y <= row.y;
        i_point_z <= row.z;
        start     <= 1'b1;
        do @(posedge i_clk); while (busy);
        r = apply_command(row.cmd, row.x, row.y, row.z);
        pending_results.push_back(row.typed ? row.res : r);
        items_sent++;
        close_hits  += r.close;
        full_hits   += r.status;
        clears_sent += (row.cmd == CMD_CLEAR);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // hold off until every result is back, then let the block settle
    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord(int span, int axis_val);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return COORD_W'($urandom);
        if (r <= 3 && axis_val != 32'h7fffffff)
            return COORD_W'(axis_val + $urandom_range(0, 2 * (span / 16 + 1)) - span / 16);
        return COORD_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic random_row(int span, int ins_pct, int clr_pct, output stim_row_t row);
        int r, s;
        r = $urandom_range(0, 99);
        row.typed = 1'b0;
        row.res   = '{1'b0, 1'b0, '0};
        if (r < clr_pct) row.cmd = CMD_CLEAR;
        else if (r < clr_pct + ins_pct) row.cmd = CMD_INSERT;
        else if (r < 98) row.cmd = CMD_QUERY;
        else row.cmd = CMD_UNUSED;
        if (site_total > 0) begin
            s = $urandom_range(0, site_total - 1);
            row.x = pick_coord(span, int'(site_px[s]));
            row.y = pick_coord(span, int'(site_py[s]));
            row.z = pick_coord(span, int'(site_pz[s]));
        end else begin
            row.x = pick_coord(span, 32'h7fffffff);
            row.y = pick_coord(span, 32'h7fffffff);
            row.z = pick_coord(span, 32'h7fffffff);
        end
    endtask

    stim_row_t directed[$];
    logic [INV_W-1:0]   ph_inv[5]  = '{32'd65536, 32'd1, 32'hFFFF_FFFF, 32'h40000, 32'h8000};
    logic [SPACE_W-1:0] ph_sp[5]   = '{52'd4294967296, 52'd0, {SPACE_W{1'b1}},
                                       52'd268435456, 52'd17179869184};
    int                 ph_n[5]    = '{350, 200, 250, 600, 250};
    int                 ph_span[5] = '{8 * 65536, 4 * 65536, 8388607, 8 * 65536, 16 * 65536};
    int                 ph_ins[5]  = '{45, 40, 50, 85, 50};
    int                 ph_clr[5]  = '{1, 5, 2, 0, 1};

    initial begin
        stim_row_t row;
        int total, done_items;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_command   <= CMD_CLEAR;
        i_point_x   <= '0;
        i_point_y   <= '0;
        i_point_z   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_INV_CELL;
        i_cfg_data  <= '0;
        inv_cell     = INV_RESET;
        min_space_sq = SPACE_RESET;
        foreach (grid_keys[i]) grid_keys[i] = 0;
        site_total = 0;
        gaps_on    = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed.push_back('{CMD_QUERY,  24'sd0, 24'sd0, 24'sd0, 1, '{0, 0, 9'd0}});
        directed.push_back('{CMD_INSERT, 24'sd0, 24'sd0, 24'sd0, 1, '{0, 0, 9'd0}});
        directed.push_back('{CMD_INSERT, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1, '{0, 0, 9'd1}});
        directed.push_back('{CMD_INSERT, 24'h800000, 24'h800000, 24'h800000, 1, '{0, 0, 9'd2}});
        directed.push_back('{CMD_QUERY,  24'sd0, 24'sd0, 24'sd0, 1, '{0, 1, 9'd0}});
        directed.push_back('{CMD_QUERY,  24'h008000, 24'sd0, 24'sd0, 1, '{0, 1, 9'd0}});
        directed.push_back('{CMD_QUERY,  24'h020000, 24'sd0, 24'sd0, 0, '{0, 0, 9'd0}});
        directed.push_back('{CMD_UNUSED, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1, '{0, 0, 9'd0}});
        directed.push_back('{CMD_QUERY,  24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1, '{0, 1, 9'd0}});
        directed.push_back('{CMD_QUERY,  24'h800000, 24'h800000, 24'h800000, 1, '{0, 1, 9'd0}});
        directed.push_back('{CMD_QUERY,  24'h7FFFFF, 24'h800000, 24'sd0, 0, '{0, 0, 9'd0}});
        directed.push_back('{CMD_INSERT, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, '{0, 0, 9'd0}});
        directed.push_back('{CMD_QUERY,  24'hFF0000, 24'hFF8000, 24'h00FFFF, 0, '{0, 0, 9'd0}});
        directed.push_back('{CMD_CLEAR,  24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1, '{0, 0, 9'd0}});
        directed.push_back('{CMD_QUERY,  24'sd0, 24'sd0, 24'sd0, 1, '{0, 0, 9'd0}});
        directed.push_back('{CMD_INSERT, 24'h123456, 24'h800001, 24'h7FFFFE, 1, '{0, 0, 9'd0}});
        directed.push_back('{CMD_QUERY,  24'h123456, 24'h800001, 24'h7FFFFE, 1, '{0, 1, 9'd0}});
        foreach (directed[i]) issue_item(directed[i]);

        total = 0;
        foreach (ph_n[p]) total += ph_n[p];
        done_items = 0;
        foreach (ph_n[p]) begin
            drain();
            write_register(CFG_INV_CELL, {20'd0, ph_inv[p]});
            write_register(CFG_SPACING, ph_sp[p]);
            for (int k = 0; k < ph_n[p]; k++) begin
                gaps_on = (done_items < total - TAIL_ITEMS);
                random_row(ph_span[p], ph_ins[p], ph_clr[p], row);
                issue_item(row);
                done_items++;
            end
        end
        drain();
        repeat (40) @(posedge i_clk);

        $display("Covered %0d items over 5 register settings: %0d clears, %0d close hits,",
                 items_sent, clears_sent, close_hits);
        $display("  %0d refused inserts, %0d mismatches", full_hits, fail_count);
        if (fail_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
